>>> hdl/wrre_pkg.sv
// Package for the windowed RTT and RTO estimator.
// Holds the mode and register index codes, sequencer types and fixed constants.
// No dependencies; imported by windowed_rtt_rto_estimator_top.
package wrre_pkg;

  localparam logic [1:0] MODE_SAMPLE = 2'd0;
  localparam logic [1:0] MODE_DOUBLE = 2'd1;
  localparam logic [1:0] MODE_HALVE  = 2'd2;
  localparam logic [1:0] MODE_CLEAR  = 2'd3;

  localparam logic [2:0] CFG_RTT_FLOOR   = 3'd0;
  localparam logic [2:0] CFG_RTT_CEILING = 3'd1;
  localparam logic [2:0] CFG_MEAN_KEEP   = 3'd2;
  localparam logic [2:0] CFG_MEAN_NEW    = 3'd3;
  localparam logic [2:0] CFG_VAR_KEEP    = 3'd4;
  localparam logic [2:0] CFG_VAR_NEW     = 3'd5;

  localparam logic [15:0] RTT_FLOOR_RST   = 16'd10;
  localparam logic [15:0] RTT_CEILING_RST = 16'd2000;
  localparam logic [16:0] MEAN_KEEP_RST   = 17'd19661;
  localparam logic [16:0] MEAN_NEW_RST    = 17'd45875;
  localparam logic [16:0] VAR_KEEP_RST    = 17'd8192;
  localparam logic [16:0] VAR_NEW_RST     = 17'd57344;

  localparam logic [2:0] BACKOFF_MAX = 3'd5;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PUSH,
    ST_INIT,
    ST_CALC,
    ST_EMIT
  } state_e;

  typedef enum logic [2:0] {
    PH_VAR_KEEP,
    PH_VAR_NEW,
    PH_MEAN_KEEP,
    PH_MEAN_NEW,
    PH_MEAN_SUM
  } phase_e;

endpackage

>>> hdl/windowed_rtt_rto_estimator_top.sv
// Top level of the windowed RTT and RTO estimator.
// Holds the handshakes, sample selection, sample window and the shared multiplier.
// Depends on wrre_pkg.
//
// Usage: input transactions carry mode, elapsed_ms, first_of_sample and
// last_of_sample and are taken when in_valid_i is high and in_stall_o is low.
// Result transactions leave on out_valid_o and are taken when out_stall_i is low.
// Registers are written over the cfg channel; cfg_ready_o is always high.
// A sample item without last_of_sample is absorbed with no result.
// Modes 1 to 3 skip the smoothing and give their result through the emit state.
// A closing sample item passes through the push and init states, then the
// smoothing steps for each window entry after the first, before its result is
// registered. These run on the single 24 by 17 bit multiplier, used four
// times per window entry plus one summing step.
// The input stays stalled from acceptance of a result-producing item until its
// result enters the output register; a stalled output holds its transaction
// while the next item may already be accepted and worked on.
// Reset clears the estimates, the window fill, the backoff and the output
// valid, and loads the register defaults.
module windowed_rtt_rto_estimator_top #(
  parameter int WINDOW_DEPTH = 6
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  mode_i,
  input  logic [15:0] elapsed_ms_i,
  input  logic        first_of_sample_i,
  input  logic        last_of_sample_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] sample_ms_o,
  output logic [23:0] rto_ms_o,
  output logic        rto_valid_o,
  output logic [23:0] mean_q8_o,
  output logic [23:0] var_q8_o,
  output logic [2:0]  backoff_exp_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [16:0] cfg_data_i
);
  import wrre_pkg::*;

  localparam int IW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int CW = $clog2(WINDOW_DEPTH + 1);

  state_e state_q, state_d;
  phase_e phase_q, phase_d;
  logic [IW-1:0] idx_q, idx_d;

  logic [15:0] floor_q, ceil_q;
  logic [16:0] mean_keep_q, mean_new_q, var_keep_q, var_new_q;

  logic [15:0] win_q [WINDOW_DEPTH];
  logic [CW-1:0] count_q;
  logic [15:0] omin_q;
  logic        omin_valid_q;
  logic        search_done_q;
  logic [15:0] cand_q;
  logic [23:0] mean_q, var_q;
  logic        est_valid_q;
  logic [2:0]  backoff_q;

  logic [15:0] rtt_q;
  logic [24:0] prod_q, acc_q;

  logic        out_valid_q;
  logic [15:0] out_sample_q;
  logic [23:0] out_rto_q, out_mean_q, out_var_q;
  logic        out_rto_valid_q;
  logic [2:0]  out_backoff_q;

  logic        in_acc, emit_fire, last_entry;
  logic [15:0] bound, cand_n, lo, raised, clamped;
  logic        sd_eff;
  logic [23:0] x_val, diff, mul_a;
  logic [16:0] mul_b;
  logic [40:0] mul_p;
  logic [25:0] sum26;
  logic [23:0] sat_sum;
  logic [26:0] rto_base;
  logic [31:0] rto_shift;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign emit_fire  = (state_q == ST_EMIT) && (!out_valid_q || !out_stall_i);
  assign cfg_ready_o = 1'b1;
  assign last_entry = (CW'(idx_q) == (count_q - CW'(1)));

  always_comb begin
    bound   = omin_valid_q ? omin_q : floor_q;
    sd_eff  = first_of_sample_i ? 1'b0 : search_done_q;
    cand_n  = sd_eff ? cand_q : elapsed_ms_i;
    lo      = omin_valid_q ? omin_q : floor_q;
    raised  = (rtt_q < lo) ? lo : rtt_q;
    clamped = (raised > ceil_q) ? ceil_q : raised;
  end

  always_comb begin
    x_val = {win_q[idx_q], 8'd0};
    diff  = (x_val >= mean_q) ? (x_val - mean_q) : (mean_q - x_val);
    case (phase_q)
      PH_VAR_KEEP: begin
        mul_a = var_q;
        mul_b = var_keep_q;
      end
      PH_VAR_NEW: begin
        mul_a = diff;
        mul_b = var_new_q;
      end
      PH_MEAN_KEEP: begin
        mul_a = mean_q;
        mul_b = mean_keep_q;
      end
      PH_MEAN_NEW: begin
        mul_a = x_val;
        mul_b = mean_new_q;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    mul_p   = {17'd0, mul_a} * {24'd0, mul_b};
    sum26   = {1'b0, acc_q} + {1'b0, prod_q};
    sat_sum = (sum26[25:24] != 2'b00) ? 24'hFFFFFF : sum26[23:0];
    rto_base  = {3'd0, mean_q} + {1'b0, var_q, 2'b00};
    rto_shift = {5'd0, rto_base} << backoff_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      phase_q <= PH_VAR_KEEP;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      idx_q   <= idx_d;
    end
  end

  always_comb begin
    state_d = state_q;
    phase_d = phase_q;
    idx_d   = idx_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (mode_i != MODE_SAMPLE) begin
            state_d = ST_EMIT;
          end else if (last_of_sample_i) begin
            state_d = ST_PUSH;
          end
        end
      end
      ST_PUSH: begin
        state_d = ST_INIT;
      end
      ST_INIT: begin
        phase_d = PH_VAR_KEEP;
        idx_d   = IW'(1);
        state_d = (count_q == CW'(1)) ? ST_EMIT : ST_CALC;
      end
      ST_CALC: begin
        case (phase_q)
          PH_VAR_KEEP:  phase_d = PH_VAR_NEW;
          PH_VAR_NEW:   phase_d = PH_MEAN_KEEP;
          PH_MEAN_KEEP: phase_d = PH_MEAN_NEW;
          PH_MEAN_NEW:  phase_d = PH_MEAN_SUM;
          default: begin
            phase_d = PH_VAR_KEEP;
            if (last_entry) begin
              state_d = ST_EMIT;
            end else begin
              idx_d = idx_q + IW'(1);
            end
          end
        endcase
      end
      ST_EMIT: begin
        if (emit_fire) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      floor_q       <= RTT_FLOOR_RST;
      ceil_q        <= RTT_CEILING_RST;
      mean_keep_q   <= MEAN_KEEP_RST;
      mean_new_q    <= MEAN_NEW_RST;
      var_keep_q    <= VAR_KEEP_RST;
      var_new_q     <= VAR_NEW_RST;
      count_q       <= '0;
      omin_q        <= '0;
      omin_valid_q  <= 1'b0;
      search_done_q <= 1'b0;
      cand_q        <= '0;
      mean_q        <= '0;
      var_q         <= '0;
      est_valid_q   <= 1'b0;
      backoff_q     <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CFG_RTT_FLOOR:   floor_q     <= cfg_data_i[15:0];
          CFG_RTT_CEILING: ceil_q      <= cfg_data_i[15:0];
          CFG_MEAN_KEEP:   mean_keep_q <= cfg_data_i;
          CFG_MEAN_NEW:    mean_new_q  <= cfg_data_i;
          CFG_VAR_KEEP:    var_keep_q  <= cfg_data_i;
          CFG_VAR_NEW:     var_new_q   <= cfg_data_i;
          default: ;
        endcase
      end

      if (in_acc) begin
        case (mode_i)
          MODE_DOUBLE: begin
            if (backoff_q < BACKOFF_MAX) begin
              backoff_q <= backoff_q + 3'd1;
            end
          end
          MODE_HALVE: begin
            if (backoff_q != 3'd0) begin
              backoff_q <= backoff_q - 3'd1;
            end
          end
          MODE_CLEAR: begin
            mean_q        <= '0;
            var_q         <= '0;
            est_valid_q   <= 1'b0;
            omin_q        <= '0;
            omin_valid_q  <= 1'b0;
            search_done_q <= 1'b0;
            cand_q        <= '0;
            backoff_q     <= '0;
          end
          default: begin
            if (first_of_sample_i && last_of_sample_i) begin
              if (!omin_valid_q || (elapsed_ms_i < omin_q)) begin
                omin_q       <= elapsed_ms_i;
                omin_valid_q <= 1'b1;
              end
              search_done_q <= 1'b0;
              cand_q        <= '0;
            end else if (last_of_sample_i) begin
              search_done_q <= 1'b0;
              cand_q        <= '0;
            end else begin
              search_done_q <= sd_eff || (elapsed_ms_i >= bound);
              cand_q        <= cand_n;
            end
          end
        endcase
      end

      if ((state_q == ST_PUSH) && (count_q != CW'(WINDOW_DEPTH))) begin
        count_q <= count_q + CW'(1);
      end

      if (state_q == ST_INIT) begin
        mean_q      <= {win_q[0], 8'd0};
        var_q       <= {1'b0, win_q[0], 7'd0};
        est_valid_q <= 1'b1;
      end

      if (state_q == ST_CALC) begin
        if (phase_q == PH_MEAN_KEEP) begin
          var_q <= sat_sum;
        end
        if (phase_q == PH_MEAN_SUM) begin
          mean_q <= sat_sum;
        end
      end

      if (emit_fire) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      if (mode_i == MODE_SAMPLE) begin
        rtt_q <= (first_of_sample_i && last_of_sample_i) ? elapsed_ms_i : cand_n;
      end else begin
        rtt_q <= '0;
      end
    end

    if (state_q == ST_PUSH) begin
      if (count_q == CW'(WINDOW_DEPTH)) begin
        for (int k = 0; k < WINDOW_DEPTH - 1; k++) begin
          win_q[k] <= win_q[k+1];
        end
        win_q[WINDOW_DEPTH-1] <= clamped;
      end else begin
        win_q[count_q[IW-1:0]] <= clamped;
      end
    end

    if (state_q == ST_CALC) begin
      prod_q <= mul_p[40:16];
      if ((phase_q == PH_VAR_NEW) || (phase_q == PH_MEAN_NEW)) begin
        acc_q <= prod_q;
      end
    end

    if (emit_fire) begin
      out_sample_q    <= rtt_q;
      out_rto_q       <= est_valid_q ? rto_shift[31:8] : 24'd0;
      out_rto_valid_q <= est_valid_q;
      out_mean_q      <= mean_q;
      out_var_q       <= var_q;
      out_backoff_q   <= backoff_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign sample_ms_o   = out_sample_q;
  assign rto_ms_o      = out_rto_q;
  assign rto_valid_o   = out_rto_valid_q;
  assign mean_q8_o     = out_mean_q;
  assign var_q8_o      = out_var_q;
  assign backoff_exp_o = out_backoff_q;

`ifndef SYNTH
  a_double_steps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (mode_i == MODE_DOUBLE) && (backoff_q < BACKOFF_MAX))
      |=> (backoff_q == $past(backoff_q) + 3'd1))
    else $error("backoff did not step up after a double request");

  a_est_has_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    est_valid_q |-> (count_q != '0))
    else $error("estimate marked valid with an empty window");

  a_calc_in_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CALC) |-> (CW'(idx_q) < count_q))
    else $error("smoothing index beyond window fill");

  a_result_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && ((mode_i != MODE_SAMPLE) || last_of_sample_i)) |=> in_stall_o)
    else $error("result-producing transaction did not start the sequencer");
`endif

endmodule
